/* src/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Types and character codes shared by the source text tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_NAME    = 4'd1,
    M_NUM     = 4'd2,
    M_DQ      = 4'd3,
    M_SQ      = 4'd4,
    M_DQ_ESC  = 4'd5,
    M_SQ_ESC  = 4'd6,
    M_EQ      = 4'd7,
    M_SLASH   = 4'd8,
    M_COMMENT = 4'd9
  } mode_t;

  typedef enum logic [3:0] {
    K_NAME       = 4'd0,
    K_NUMBER     = 4'd1,
    K_STRING     = 4'd2,
    K_NOT        = 4'd3,
    K_LPAREN     = 4'd4,
    K_RPAREN     = 4'd5,
    K_OPERATOR   = 4'd6,
    K_COMMA      = 4'd7,
    K_DOT        = 4'd8,
    K_COMPARISON = 4'd9
  } kind_t;

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       valid;
    logic       first;
    logic       last;
  } res_t;

  // lexer state plus the results of one byte
  typedef struct packed {
    mode_t           mode;
    logic [7:0]      held;
    logic            held_valid;
    logic            started;
    res_t [1:0]      res;
    logic [1:0]      cnt;
  } lex_t;

  localparam int unsigned MAX_RES = 2;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QAW     = $clog2(QDEPTH);

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage

/* src/source_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: one source byte in, token characters out with class and
// first / last marks.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while the four-entry result queue has room
// for two results; the whole transition for the byte, including its one byte
// of lookahead, is worked out in that cycle and its results are written to the
// queue in the cycle after. The single result port drains one result per cycle
// while out_ready is high, so a stream whose bytes each give at most one result
// runs at one byte per cycle, and bytes that give two results (a closed token
// followed by punctuation, or '==') fill the queue faster than it drains.
module source_text_tokenizer
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_of_buffer,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_token_kind,
  output logic [7:0] out_token_char,
  output logic       out_char_valid,
  output logic       out_token_first,
  output logic       out_token_last
);

  function automatic lex_t f_put(input lex_t s, input kind_t k, input logic [7:0] ch,
                                 input logic v, input logic f, input logic l);
    lex_t o;
    o = s;
    if (s.cnt < 2'(MAX_RES)) begin
      o.res[s.cnt[0]] = '{kind: k, ch: ch, valid: v, first: f, last: l};
      o.cnt = s.cnt + 2'd1;
    end
    return o;
  endfunction

  function automatic lex_t f_send_held(input lex_t s, input logic last);
    lex_t  o;
    kind_t k;
    o = s;
    case (s.mode)
      M_NAME:  k = K_NAME;
      M_NUM:   k = K_NUMBER;
      default: k = K_STRING;
    endcase
    if (s.held_valid) begin
      o = f_put(o, k, s.held, 1'b1, !s.started, last);
      o.started = 1'b1;
      o.held_valid = 1'b0;
    end
    return o;
  endfunction

  function automatic lex_t f_close_string(input lex_t s);
    lex_t o;
    o = s;
    if (s.held_valid) o = f_send_held(o, 1'b1);
    else o = f_put(o, K_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
    return o;
  endfunction

  function automatic lex_t f_go_idle(input lex_t s);
    lex_t o;
    o = s;
    o.mode = M_IDLE;
    o.held_valid = 1'b0;
    o.started = 1'b0;
    return o;
  endfunction

  function automatic lex_t f_hold(input lex_t s, input logic [7:0] b);
    lex_t o;
    o = s;
    o.held = b;
    o.held_valid = 1'b1;
    return o;
  endfunction

  function automatic lex_t f_dispatch(input lex_t s, input logic [7:0] b);
    lex_t o;
    o = f_go_idle(s);
    if (is_letter(b)) begin
      o.mode = M_NAME;
      o = f_hold(o, b);
    end else if (is_digit(b)) begin
      o.mode = M_NUM;
      o = f_hold(o, b);
    end else begin
      case (b)
        CH_BANG:   o = f_put(o, K_NOT, b, 1'b1, 1'b1, 1'b1);
        CH_DQUOTE: o.mode = M_DQ;
        CH_SQUOTE: o.mode = M_SQ;
        CH_LPAREN: o = f_put(o, K_LPAREN, b, 1'b1, 1'b1, 1'b1);
        CH_RPAREN: o = f_put(o, K_RPAREN, b, 1'b1, 1'b1, 1'b1);
        CH_STAR, CH_PLUS, CH_MINUS: o = f_put(o, K_OPERATOR, b, 1'b1, 1'b1, 1'b1);
        CH_COMMA:  o = f_put(o, K_COMMA, b, 1'b1, 1'b1, 1'b1);
        CH_DOT:    o = f_put(o, K_DOT, b, 1'b1, 1'b1, 1'b1);
        CH_LT, CH_GT: o = f_put(o, K_COMPARISON, b, 1'b1, 1'b1, 1'b1);
        CH_EQ:     o.mode = M_EQ;
        CH_SLASH:  o.mode = M_SLASH;
        default:   o = o;
      endcase
    end
    return o;
  endfunction

  function automatic lex_t f_string(input lex_t s, input logic [7:0] b,
                                    input logic [7:0] quote, input mode_t esc);
    lex_t o;
    o = s;
    if (b == quote) begin
      o = f_close_string(o);
      o = f_go_idle(o);
    end else begin
      o = f_send_held(o, 1'b0);
      o = f_hold(o, b);
      if (b == CH_BSLASH) o.mode = esc;
    end
    return o;
  endfunction

  mode_t      mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       started_r, started_nxt;

  res_t             q_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;

  lex_t       st;
  logic       accept, pop;
  logic [1:0] push_cnt;

  always_comb begin
    st = '{mode: mode_r, held: held_r, held_valid: held_valid_r, started: started_r,
           res: '0, cnt: 2'd0};
    case (mode_r)
      M_NAME: begin
        if (is_letter(in_char_byte) || is_digit(in_char_byte)) begin
          st = f_send_held(st, 1'b0);
          st = f_hold(st, in_char_byte);
        end else begin
          st = f_send_held(st, 1'b1);
          st = f_dispatch(st, in_char_byte);
        end
      end
      M_NUM: begin
        if (is_digit(in_char_byte)) begin
          st = f_send_held(st, 1'b0);
          st = f_hold(st, in_char_byte);
        end else begin
          st = f_send_held(st, 1'b1);
          st = f_dispatch(st, in_char_byte);
        end
      end
      M_DQ: st = f_string(st, in_char_byte, CH_DQUOTE, M_DQ_ESC);
      M_SQ: st = f_string(st, in_char_byte, CH_SQUOTE, M_SQ_ESC);
      M_DQ_ESC, M_SQ_ESC: begin
        st = f_send_held(st, 1'b0);
        st = f_hold(st, in_char_byte);
        st.mode = (mode_r == M_DQ_ESC) ? M_DQ : M_SQ;
      end
      M_EQ: begin
        if (in_char_byte == CH_EQ) begin
          st = f_put(st, K_COMPARISON, CH_EQ, 1'b1, 1'b1, 1'b0);
          st = f_put(st, K_COMPARISON, CH_EQ, 1'b1, 1'b0, 1'b1);
          st = f_go_idle(st);
        end else begin
          st = f_put(st, K_OPERATOR, CH_EQ, 1'b1, 1'b1, 1'b1);
          st = f_dispatch(st, in_char_byte);
        end
      end
      M_SLASH: begin
        if (in_char_byte == CH_SLASH) begin
          st = f_go_idle(st);
          st.mode = M_COMMENT;
        end else begin
          st = f_put(st, K_OPERATOR, CH_SLASH, 1'b1, 1'b1, 1'b1);
          st = f_dispatch(st, in_char_byte);
        end
      end
      M_COMMENT: begin
        if (in_char_byte == CH_NL) st = f_go_idle(st);
      end
      default: st = f_dispatch(st, in_char_byte);
    endcase

    // close any open name, number, string or pending '=' at the end of the buffer; a pending '/' is dropped
    if (in_end_of_buffer) begin
      case (st.mode)
        M_NAME, M_NUM: st = f_send_held(st, 1'b1);
        M_DQ, M_SQ, M_DQ_ESC, M_SQ_ESC: st = f_close_string(st);
        M_EQ: st = f_put(st, K_OPERATOR, CH_EQ, 1'b1, 1'b1, 1'b1);
        default: st = st;
      endcase
      st = f_go_idle(st);
    end
  end

  // room for the worst case of two results
  assign in_ready  = count_r <= (QAW+1)'(QDEPTH - MAX_RES);
  assign accept    = in_valid && in_ready;
  assign out_valid = count_r != '0;
  assign pop       = out_valid && out_ready;
  assign push_cnt  = accept ? st.cnt : 2'd0;

  always_comb begin
    mode_nxt       = mode_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    started_nxt    = started_r;
    if (accept) begin
      mode_nxt       = st.mode;
      held_nxt       = st.held;
      held_valid_nxt = st.held_valid;
      started_nxt    = st.started;
    end
    count_nxt = count_r + (QAW+1)'(push_cnt) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      held_r       <= 8'h00;
      held_valid_r <= 1'b0;
      started_r    <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      count_r      <= '0;
    end else begin
      mode_r       <= mode_nxt;
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      started_r    <= started_nxt;
      wr_ptr_r     <= wr_ptr_r + QAW'(push_cnt);
      rd_ptr_r     <= rd_ptr_r + QAW'(pop);
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) q_r[wr_ptr_r] <= st.res[0];
    if (push_cnt == 2'd2) q_r[wr_ptr_r + QAW'(1)] <= st.res[1];
  end

  assign out_token_kind  = q_r[rd_ptr_r].kind;
  assign out_token_char  = q_r[rd_ptr_r].ch;
  assign out_char_valid  = q_r[rd_ptr_r].valid;
  assign out_token_first = q_r[rd_ptr_r].first;
  assign out_token_last  = q_r[rd_ptr_r].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("result queue overfilled");

  a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r == $past(count_r) + (QAW+1)'($past(push_cnt)) - (QAW+1)'($past(pop)))
    else $error("result queue count out of step");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_IDLE || mode_r == M_EQ || mode_r == M_SLASH || mode_r == M_COMMENT)
    |-> (!held_valid_r && !started_r))
    else $error("character held outside a token");

  a_escape_held: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_DQ_ESC || mode_r == M_SQ_ESC) |-> (held_valid_r && held_r == CH_BSLASH))
    else $error("escape mode without a held backslash");

  a_eob_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_of_buffer) |=> (mode_r == M_IDLE && !held_valid_r))
    else $error("lexer not idle after end of buffer");

endmodule
